@@ rtl/qee_pkg.sv @@
// Shared constants, request kinds and helpers for the queue edit engine.
package qee_pkg;

  localparam int Depth = 64;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  localparam logic [3:0] KindEnq      = 4'd0;
  localparam logic [3:0] KindDeq      = 4'd1;
  localparam logic [3:0] KindSorted   = 4'd2;
  localparam logic [3:0] KindRemAll   = 4'd3;
  localparam logic [3:0] KindRemFirst = 4'd4;
  localparam logic [3:0] KindRemLast  = 4'd5;
  localparam logic [3:0] KindRemSec   = 4'd6;
  localparam logic [3:0] KindInsAfter = 4'd7;
  localparam logic [3:0] KindCount    = 4'd8;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatFull  = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DEQ  = 11'b000_0000_0010,
    S_CRD  = 11'b000_0000_0100,
    S_CEV  = 11'b000_0000_1000,
    S_BRD  = 11'b000_0001_0000,
    S_BEV  = 11'b000_0010_0000,
    S_BEX  = 11'b000_0100_0000,
    S_TAIL = 11'b000_1000_0000,
    S_PRD  = 11'b001_0000_0000,
    S_PWR  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  // Physical address of the entry at logical position pos behind head.
  function automatic logic [AddrW-1:0] wrap_addr(logic [AddrW-1:0] head,
                                                 logic [CntW-1:0] pos);
    logic [AddrW:0] sum;
    sum = {1'b0, head} + {1'b0, pos[AddrW-1:0]};
    if (sum >= (AddrW+1)'(Depth)) begin
      sum = sum - (AddrW+1)'(Depth);
    end
    return sum[AddrW-1:0];
  endfunction

endpackage

@@ rtl/qee_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module qee_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/queue_edit_engine.sv @@
// Top level of the queue edit engine: bounded FIFO with value-based editing.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser: kind; tdata: value, insert_value
//  m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: data, match_count, status, occupancy
//
// Enqueue and requests that change nothing go straight to the result state;
// dequeue first reads the head entry. Editing requests (kinds two to eight)
// count matches in one pass, rebuild the sequence into a scratch RAM in a
// second, with an extra step per inserted word, and copy it back in a third,
// each pass reading one element at a time. Reset clears the head, count and
// sequencer; store contents are undefined until written. A stalled result holds
// the sequencer in its final state, and a new request is taken only when idle.
module queue_edit_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] value, [63:32] insert_value
  input  logic [3:0]  s_axis_tuser,  // [3:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [31:0] data, [38:32] match_count,
                                     // [40:39] status, [47:41] occupancy
);

  localparam int AW = qee_pkg::AddrW;
  localparam int CW = qee_pkg::CntW;

  qee_pkg::state_e state_q, state_d;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [3:0]    kind_q, kind_d;
  logic [31:0]   key_q, key_d, ins_q, ins_d;
  logic [CW-1:0] idx_q, idx_d;      // element index in the current pass
  logic [CW-1:0] len_q, len_d;      // length of the sequence being built
  logic [CW-1:0] total_q, total_d;  // matches found by the counting pass
  logic [CW-1:0] seen_q, seen_d;    // matches passed so far while rebuilding
  logic          placed_q, placed_d;
  logic          drop_q, drop_d;
  logic [31:0]   extra_q, extra_d;  // second word owed by the previous element
  logic [31:0]   data_q, data_d;
  logic [1:0]    stat_q, stat_d;

  logic          ovalid_q, ovalid_d;
  logic [47:0]   odata_q, odata_d;

  // Store RAM port controls.
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [31:0]   st_wdata, st_rdata;
  // Scratch RAM port controls.
  logic          sc_we;
  logic [AW-1:0] sc_waddr, sc_raddr;
  logic [31:0]   sc_wdata, sc_rdata;

  logic          in_fire;
  logic [CW-1:0] target;
  logic [CW-1:0] seen_n;
  logic          eq;
  logic          gt;
  logic [31:0]   put_word;
  logic          put_en;

  assign s_axis_tready = (state_q == qee_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  qee_ram #(.Width(32), .Depth(qee_pkg::Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  qee_ram #(.Width(32), .Depth(qee_pkg::Depth)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (sc_waddr),
    .wdata_i (sc_wdata),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

  // Compare unit shared by the counting and rebuilding passes.
  assign eq     = (st_rdata == key_q);
  assign gt     = ($signed(st_rdata) > $signed(key_q));
  assign seen_n = seen_q + CW'(eq);

  always_comb begin
    priority if (kind_q == qee_pkg::KindRemFirst) begin
      target = CW'(1);
    end else if (kind_q == qee_pkg::KindRemLast) begin
      target = total_q;
    end else begin
      target = CW'(2);
    end
  end

  // Every word appended to the new sequence goes through this one write port.
  assign sc_we    = put_en && (len_q < CW'(qee_pkg::Depth));
  assign sc_waddr = len_q[AW-1:0];
  assign sc_wdata = put_word;
  assign sc_raddr = idx_q[AW-1:0];

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    kind_d   = kind_q;
    key_d    = key_q;
    ins_d    = ins_q;
    idx_d    = idx_q;
    len_d    = len_q;
    total_d  = total_q;
    seen_d   = seen_q;
    placed_d = placed_q;
    drop_d   = drop_q;
    extra_d  = extra_q;
    data_d   = data_q;
    stat_d   = stat_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    st_we    = 1'b0;
    st_waddr = qee_pkg::wrap_addr(head_q, count_q);
    st_wdata = key_q;
    st_raddr = qee_pkg::wrap_addr(head_q, idx_q);
    put_en   = 1'b0;
    put_word = st_rdata;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      qee_pkg::S_IDLE: begin
        if (in_fire) begin
          kind_d   = s_axis_tuser;
          key_d    = s_axis_tdata[31:0];
          ins_d    = s_axis_tdata[63:32];
          data_d   = '0;
          stat_d   = qee_pkg::StatOk;
          idx_d    = '0;
          len_d    = '0;
          total_d  = '0;
          seen_d   = '0;
          placed_d = 1'b0;
          drop_d   = 1'b0;
          st_raddr = head_q;
          priority if (s_axis_tuser == qee_pkg::KindEnq) begin
            if (count_q >= CW'(qee_pkg::Depth)) begin
              stat_d = qee_pkg::StatFull;
            end else begin
              st_we    = 1'b1;
              st_wdata = s_axis_tdata[31:0];
              count_d  = count_q + CW'(1);
            end
            state_d = qee_pkg::S_DONE;
          end else if (s_axis_tuser == qee_pkg::KindDeq) begin
            if (count_q == '0) begin
              stat_d  = qee_pkg::StatEmpty;
              state_d = qee_pkg::S_DONE;
            end else begin
              state_d = qee_pkg::S_DEQ;
            end
          end else if (s_axis_tuser >= qee_pkg::KindSorted &&
                       s_axis_tuser <= qee_pkg::KindCount) begin
            state_d = qee_pkg::S_CRD;
          end else begin
            state_d = qee_pkg::S_DONE;
          end
        end
      end
      qee_pkg::S_DEQ: begin
        data_d  = st_rdata;
        head_d  = qee_pkg::wrap_addr(head_q, CW'(1));
        count_d = count_q - CW'(1);
        state_d = qee_pkg::S_DONE;
      end
      qee_pkg::S_CRD: begin
        if (idx_q == count_q) begin
          idx_d   = '0;
          state_d = qee_pkg::S_BRD;
        end else begin
          state_d = qee_pkg::S_CEV;
        end
      end
      qee_pkg::S_CEV: begin
        total_d = total_q + CW'(eq);
        idx_d   = idx_q + CW'(1);
        state_d = qee_pkg::S_CRD;
      end
      qee_pkg::S_BRD: begin
        if (idx_q == count_q) begin
          idx_d = '0;
          if (kind_q == qee_pkg::KindSorted && !placed_q) begin
            state_d = qee_pkg::S_TAIL;
          end else begin
            state_d = qee_pkg::S_PRD;
          end
        end else begin
          state_d = qee_pkg::S_BEV;
        end
      end
      qee_pkg::S_BEV: begin
        seen_d  = seen_n;
        idx_d   = idx_q + CW'(1);
        state_d = qee_pkg::S_BRD;
        priority if (kind_q == qee_pkg::KindSorted) begin
          put_en = 1'b1;
          if (!placed_q && gt) begin
            // The key goes in front of the first greater entry.
            put_word = key_q;
            placed_d = 1'b1;
            extra_d  = st_rdata;
            idx_d    = idx_q;
            state_d  = qee_pkg::S_BEX;
          end
        end else if (kind_q == qee_pkg::KindRemAll) begin
          put_en = !eq;
        end else if (kind_q == qee_pkg::KindInsAfter) begin
          put_en = 1'b1;
          if (eq) begin
            extra_d = ins_q;
            idx_d   = idx_q;
            state_d = qee_pkg::S_BEX;
          end
        end else if (kind_q == qee_pkg::KindCount) begin
          put_en = 1'b1;
        end else begin
          put_en = !(eq && seen_n == target);
        end
      end
      qee_pkg::S_BEX: begin
        put_en   = 1'b1;
        put_word = extra_q;
        idx_d    = idx_q + CW'(1);
        state_d  = qee_pkg::S_BRD;
      end
      qee_pkg::S_TAIL: begin
        put_en   = 1'b1;
        put_word = key_q;
        state_d  = qee_pkg::S_PRD;
      end
      qee_pkg::S_PRD: begin
        if (idx_q == len_q) begin
          state_d = qee_pkg::S_DONE;
        end else begin
          state_d = qee_pkg::S_PWR;
        end
      end
      qee_pkg::S_PWR: begin
        st_we    = 1'b1;
        st_waddr = idx_q[AW-1:0];
        st_wdata = sc_rdata;
        idx_d    = idx_q + CW'(1);
        state_d  = qee_pkg::S_PRD;
      end
      qee_pkg::S_DONE: begin
        if (!ovalid_q || m_axis_tready) begin
          logic [CW-1:0] occ;
          logic [CW-1:0] mc;
          logic [1:0]    st;
          occ = count_q;
          mc  = '0;
          st  = stat_q;
          if (kind_q >= qee_pkg::KindSorted && kind_q <= qee_pkg::KindCount) begin
            head_d  = '0;
            count_d = len_q;
            occ     = len_q;
            if (drop_q) begin
              st = qee_pkg::StatFull;
            end
            if (kind_q == qee_pkg::KindCount) begin
              mc = total_q;
            end
          end
          ovalid_d = 1'b1;
          odata_d  = {7'(occ), st, 7'(mc), data_q};
          state_d  = qee_pkg::S_IDLE;
        end
      end
      default: state_d = qee_pkg::S_IDLE;
    endcase

    if (put_en) begin
      if (len_q < CW'(qee_pkg::Depth)) begin
        len_d = len_q + CW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= qee_pkg::S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    key_q    <= key_d;
    ins_q    <= ins_d;
    idx_q    <= idx_d;
    len_q    <= len_d;
    total_q  <= total_d;
    seen_q   <= seen_d;
    placed_q <= placed_d;
    drop_q   <= drop_d;
    extra_q  <= extra_d;
    data_q   <= data_d;
    stat_q   <= stat_d;
    odata_q  <= odata_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(qee_pkg::Depth))
    else $error("occupancy exceeds depth");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("request taken while previous still in progress");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qee_pkg::S_PRD) |-> (len_q <= CW'(qee_pkg::Depth)))
    else $error("rebuilt length exceeds depth");
`endif

endmodule
